>>> hw/rtl/cc20_pkg.sv
// Shared types and constants for the ChaCha20 block function pipeline.
package cc20_pkg;

    localparam int WORD_W        = 32;
    localparam int NUM_WORDS     = 16;
    localparam int NUM_KEY_WORDS = 8;
    localparam int KEY_IDX_W     = 3;
    localparam int CFG_INDEX_W   = 4;
    localparam int STEPS_PER_DR  = 8;

    // "expand 32-byte k"
    localparam logic [WORD_W-1:0] SIGMA_0 = 32'h61707865;
    localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320646e;
    localparam logic [WORD_W-1:0] SIGMA_2 = 32'h79622d32;
    localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b206574;

    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;

    typedef struct packed {
        logic [31:0] block_counter;
        logic [31:0] nonce_word_0;
        logic [31:0] nonce_word_1;
        logic [31:0] nonce_word_2;
    } cc20_in_t;

    typedef struct packed {
        logic [63:0] out_words_0_1;
        logic [63:0] out_words_2_3;
        logic [63:0] out_words_4_5;
        logic [63:0] out_words_6_7;
        logic [63:0] out_words_8_9;
        logic [63:0] out_words_10_11;
        logic [63:0] out_words_12_13;
        logic [63:0] out_words_14_15;
    } cc20_out_t;

    // working state plus the per-block input words needed for the final add
    typedef struct packed {
        state_t   work;
        cc20_in_t init_tail;
    } stage_t;

endpackage

>>> hw/rtl/cc20_step.sv
// One pipeline stage: one add/xor/rotate step of four parallel quarter rounds.
module cc20_step
    import cc20_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  stage_t in_stage,
    output logic   out_valid,
    output stage_t out_stage
);

    localparam int HALF = STEP / 4;     // 0: column round, 1: diagonal round
    localparam int SUB  = STEP % 4;     // which of the four quarter-round steps
    localparam int ROT  = (SUB == 0) ? 16 : (SUB == 1) ? 12 : (SUB == 2) ? 8 : 7;

    logic   valid_reg;
    stage_t stage_reg;
    stage_t stage_next;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x);
        return (x << ROT) | (x >> (WORD_W - ROT));
    endfunction

    assign stage_next.init_tail = in_stage.init_tail;

    for (genvar q = 0; q < 4; q++) begin : g_quarter
        localparam int IA = q;
        localparam int IB = 4 + ((q + HALF) % 4);
        localparam int IC = 8 + ((q + 2 * HALF) % 4);
        localparam int ID = 12 + ((q + 3 * HALF) % 4);

        logic [WORD_W-1:0] sum;

        if (SUB == 0 || SUB == 2) begin : g_ad
            // a += b; d = rotl(d ^ a)
            assign sum = in_stage.work[IA] + in_stage.work[IB];
            assign stage_next.work[IA] = sum;
            assign stage_next.work[ID] = rotl(in_stage.work[ID] ^ sum);
            assign stage_next.work[4 + q] = in_stage.work[4 + q];
            assign stage_next.work[8 + q] = in_stage.work[8 + q];
        end
        else begin : g_cb
            // c += d; b = rotl(b ^ c)
            assign sum = in_stage.work[IC] + in_stage.work[ID];
            assign stage_next.work[IC] = sum;
            assign stage_next.work[IB] = rotl(in_stage.work[IB] ^ sum);
            assign stage_next.work[q] = in_stage.work[q];
            assign stage_next.work[12 + q] = in_stage.work[12 + q];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

>>> hw/rtl/chacha20_block_function_core.sv
// Top level of the pipelined ChaCha20 block function core.
//
// Usage:
//   Load the 256-bit key through the cfg channel (cfg_index 0..7 = key words
//   0..7, little-endian); cfg_ready is always high, other indexes are dropped.
//   Change the key only while no block is in flight.
//   Each word on the input channel (counter plus three nonce words) yields
//   one 512-bit keystream block on the output channel, as eight 64-bit pairs.
// Pipeline:
//   One register stage per add/xor/rotate step of every half round, then the
//   final feed-forward add register. A new word is accepted every cycle
//   unless the pipeline is stalled.
// Reset:
//   Clears all key words to zero and empties the pipeline.
// Stall:
//   While the output word is held by out_stall the whole pipeline freezes and
//   in_stall is raised; nothing is dropped or duplicated.
module chacha20_block_function_core
    import cc20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  cc20_in_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output cc20_out_t              out_data
);

    localparam int NSTEP = STEPS_PER_DR * DOUBLE_ROUNDS;

    logic [NUM_KEY_WORDS-1:0][WORD_W-1:0] key_reg;

    logic      en;
    logic      chain_valid [0:NSTEP];
    stage_t    chain       [0:NSTEP];
    state_t    init_state;
    state_t    fin;
    cc20_out_t out_next;
    cc20_out_t out_data_reg;
    logic      out_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_valid && cfg_index < CFG_INDEX_W'(NUM_KEY_WORDS))
        begin
            key_reg[cfg_index[KEY_IDX_W-1:0]] <= cfg_data;
        end
    end

    // global advance: freeze everything while the output word is held
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    assign chain_valid[0]     = in_valid;
    assign chain[0].init_tail = in_data;
    assign chain[0].work      = {in_data.nonce_word_2, in_data.nonce_word_1,
                                 in_data.nonce_word_0, in_data.block_counter,
                                 key_reg,
                                 SIGMA_3, SIGMA_2, SIGMA_1, SIGMA_0};

    for (genvar s = 0; s < NSTEP; s++) begin : g_step
        cc20_step #(
            .STEP (s % STEPS_PER_DR)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[s]),
            .in_stage  (chain[s]),
            .out_valid (chain_valid[s + 1]),
            .out_stage (chain[s + 1])
        );
    end

    assign init_state = {chain[NSTEP].init_tail.nonce_word_2,
                         chain[NSTEP].init_tail.nonce_word_1,
                         chain[NSTEP].init_tail.nonce_word_0,
                         chain[NSTEP].init_tail.block_counter,
                         key_reg,
                         SIGMA_3, SIGMA_2, SIGMA_1, SIGMA_0};

    always_comb
    begin
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            fin[i] = chain[NSTEP].work[i] + init_state[i];
        end
        out_next.out_words_0_1   = {fin[1],  fin[0]};
        out_next.out_words_2_3   = {fin[3],  fin[2]};
        out_next.out_words_4_5   = {fin[5],  fin[4]};
        out_next.out_words_6_7   = {fin[7],  fin[6]};
        out_next.out_words_8_9   = {fin[9],  fin[8]};
        out_next.out_words_10_11 = {fin[11], fin[10]};
        out_next.out_words_12_13 = {fin[13], fin[12]};
        out_next.out_words_14_15 = {fin[15], fin[14]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= chain_valid[NSTEP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> tb/tb_chacha20_block_function_core.sv
// Self-checking testbench for the ChaCha20 block function core: directed and random blocks.
`timescale 1ns / 1ps

module tb_chacha20_block_function_core;
    import cc20_pkg::*;

    localparam int DOUBLE_ROUNDS   = 10;
    localparam int LATENCY         = 8 * DOUBLE_ROUNDS + 1;
    localparam int RAND_PHASES     = 5;
    localparam int ITEMS_PER_PHASE = 226;
    localparam int HOLD_CYCLES     = 300;
    localparam int RUN_LIMIT_NS    = 4_000_000;
    localparam int MAX_PRINTS      = 40;
    // cfg indexes at and above this one hit no register
    localparam int FIRST_UNUSED_INDEX = NUM_KEY_WORDS;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [7:0][63:0]  pair_vec_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]      cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    cc20_in_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    cc20_out_t              out_data;

    word_t     key_shadow [NUM_KEY_WORDS];
    cc20_in_t  pending_blocks [$];
    cc20_out_t keystream_expected [$];

    int n_errors   = 0;
    int n_results  = 0;
    int idle_left  = 0;
    int calm_in    = 0;
    int stall_left = 0;
    int calm_out   = 0;
    int hold_left  = 0;
    int holds_done = 0;

    chacha20_block_function_core #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic word_t rotl(word_t x, int r);
        return (x << r) | (x >> (WORD_W - r));
    endfunction

    function automatic logic [127:0] quarter_round(word_t a, word_t b, word_t c, word_t d);
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        return {a, b, c, d};
    endfunction

    // Expected keystream for one block under the current key.
    function automatic cc20_out_t keystream_block(cc20_in_t blk);
        word_t     init [NUM_WORDS];
        word_t     x [NUM_WORDS];
        pair_vec_t pairs;
        init[0] = SIGMA_0;
        init[1] = SIGMA_1;
        init[2] = SIGMA_2;
        init[3] = SIGMA_3;
        for (int k = 0; k < NUM_KEY_WORDS; k++)
            init[4 + k] = key_shadow[k];
        init[12] = blk.block_counter;
        init[13] = blk.nonce_word_0;
        init[14] = blk.nonce_word_1;
        init[15] = blk.nonce_word_2;
        x = init;
        for (int r = 0; r < DOUBLE_ROUNDS; r++)
        begin
            {x[0], x[4], x[8],  x[12]} = quarter_round(x[0], x[4], x[8],  x[12]);
            {x[1], x[5], x[9],  x[13]} = quarter_round(x[1], x[5], x[9],  x[13]);
            {x[2], x[6], x[10], x[14]} = quarter_round(x[2], x[6], x[10], x[14]);
            {x[3], x[7], x[11], x[15]} = quarter_round(x[3], x[7], x[11], x[15]);
            {x[0], x[5], x[10], x[15]} = quarter_round(x[0], x[5], x[10], x[15]);
            {x[1], x[6], x[11], x[12]} = quarter_round(x[1], x[6], x[11], x[12]);
            {x[2], x[7], x[8],  x[13]} = quarter_round(x[2], x[7], x[8],  x[13]);
            {x[3], x[4], x[9],  x[14]} = quarter_round(x[3], x[4], x[9],  x[14]);
        end
        for (int i = 0; i < NUM_WORDS; i++)
            x[i] = x[i] + init[i];
        // first struct field sits in the top slot of the packed vector
        for (int j = 0; j < 8; j++)
            pairs[7 - j] = {x[2 * j + 1], x[2 * j]};
        return cc20_out_t'(pairs);
    endfunction

    function automatic word_t rand_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return word_t'(1) << $urandom_range(0, WORD_W - 1);
            default: return $urandom();
        endcase
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (n_errors < MAX_PRINTS)
            $display("[%0t] mismatch %s: got %h, expected %h", $time, what, got, want);
        n_errors++;
    endtask

    task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, word_t data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < FIRST_UNUSED_INDEX)
            key_shadow[idx[KEY_IDX_W-1:0]] = data;
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_blocks.size() != 0 || in_valid || keystream_expected.size() != 0);
    endtask

    // Sender: presents queued blocks, holds a stalled word, idles at random.
    always @(posedge clk)
    begin : block_driver
        if (rst_n && !(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                keystream_expected.push_back(keystream_block(in_data));
                if (calm_in > 0)
                begin
                    calm_in--;
                    idle_left = 0;
                end
                else
                begin
                    idle_left = pick_gap();
                    if ($urandom_range(0, 24) == 0)
                        calm_in = $urandom_range(30, 120);
                end
            end
            if (idle_left > 0)
            begin
                idle_left--;
                in_valid <= 1'b0;
            end
            else if (pending_blocks.size() > 0)
            begin
                in_data  <= pending_blocks.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: checks each word against the oldest expectation, stalls at random.
    always @(posedge clk)
    begin : result_monitor
        pair_vec_t got_pairs;
        pair_vec_t want_pairs;
        logic      stall_now;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                n_results++;
                got_pairs = pair_vec_t'(out_data);
                if (keystream_expected.size() == 0)
                    report_mismatch("word with no block pending", got_pairs[7], '0);
                else
                begin
                    want_pairs = pair_vec_t'(keystream_expected.pop_front());
                    for (int j = 0; j < 8; j++)
                        if (got_pairs[7 - j] !== want_pairs[7 - j])
                            report_mismatch($sformatf("out_words_%0d_%0d", 2 * j, 2 * j + 1),
                                            got_pairs[7 - j], want_pairs[7 - j]);
                end
            end
            stall_now = 1'b0;
            if (stall_left > 0)
            begin
                stall_left--;
                stall_now = 1'b1;
            end
            else if (calm_out > 0)
                calm_out--;
            else
            begin
                stall_left = pick_gap();
                if ($urandom_range(0, 24) == 0)
                    calm_out = $urandom_range(30, 120);
            end
            out_stall <= stall_now || (hold_left != 0);
        end
    end

    // Long receiver hold-off while plenty of blocks are queued, so the pipe backs up.
    always @(posedge clk)
    begin : receiver_hold
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (rst_n && holds_done < 2 && n_results >= 100 + 500 * holds_done
                 && pending_blocks.size() > 100)
        begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    initial
    begin : stimulus
        word_t kw;
        for (int k = 0; k < NUM_KEY_WORDS; k++)
            key_shadow[k] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // key as left by reset
        pending_blocks.push_back(cc20_in_t'{32'h0, 32'h0, 32'h0, 32'h0});
        pending_blocks.push_back(cc20_in_t'{32'hffffffff, 32'hffffffff, 32'hffffffff,
                                            32'hffffffff});
        pending_blocks.push_back(cc20_in_t'{32'hffffffff, 32'h0, 32'h0, 32'h0});
        pending_blocks.push_back(cc20_in_t'{32'h0, 32'h80000000, 32'h1, 32'h80000000});
        pending_blocks.push_back(cc20_in_t'{32'h1, 32'h09000000, 32'h4a000000, 32'h0});
        wait_idle();

        // standard test key 00..1f, then writes to unused indexes must change nothing
        for (int k = 0; k < NUM_KEY_WORDS; k++)
            write_cfg(CFG_INDEX_W'(k), 32'h03020100 + 32'h04040404 * k);
        for (int i = FIRST_UNUSED_INDEX; i < (1 << CFG_INDEX_W); i++)
            write_cfg(CFG_INDEX_W'(i), $urandom());
        pending_blocks.push_back(cc20_in_t'{32'h1, 32'h09000000, 32'h4a000000, 32'h0});
        pending_blocks.push_back(cc20_in_t'{32'h1, 32'h0, 32'h4a000000, 32'h0});
        pending_blocks.push_back(cc20_in_t'{32'h0, 32'h0, 32'h0, 32'h0});
        pending_blocks.push_back(cc20_in_t'{32'hffffffff, 32'h0, 32'h4a000000, 32'h0});
        wait_idle();

        // all-ones key
        for (int k = 0; k < NUM_KEY_WORDS; k++)
            write_cfg(CFG_INDEX_W'(k), '1);
        pending_blocks.push_back(cc20_in_t'{32'h0, 32'h0, 32'h0, 32'h0});
        pending_blocks.push_back(cc20_in_t'{32'hffffffff, 32'hffffffff, 32'hffffffff,
                                            32'hffffffff});
        pending_blocks.push_back(cc20_in_t'{32'ha5a5a5a5, 32'h5a5a5a5a, 32'ha5a5a5a5,
                                            32'h5a5a5a5a});
        pending_blocks.push_back(cc20_in_t'{32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                            32'h80000000});
        wait_idle();

        // random keys, last phase writes an explicit all-zero key
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            for (int k = 0; k < NUM_KEY_WORDS; k++)
            begin
                kw = (p == RAND_PHASES - 1) ? word_t'(0) : rand_word();
                write_cfg(CFG_INDEX_W'(k), kw);
            end
            write_cfg(CFG_INDEX_W'($urandom_range(FIRST_UNUSED_INDEX, (1 << CFG_INDEX_W) - 1)),
                      $urandom());
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                pending_blocks.push_back(cc20_in_t'{rand_word(), rand_word(), rand_word(),
                                                    rand_word()});
            wait_idle();
        end

        // any stray word would show up within one pipeline depth
        repeat (LATENCY + 20) @(posedge clk);
        if (n_errors == 0)
            $display("** chacha20_block_function_core: PASSED **");
        else
            $display("** chacha20_block_function_core: FAILED **");
        $finish;
    end

    initial
    begin : run_limit
        #(RUN_LIMIT_NS);
        $display("** chacha20_block_function_core: FAILED **");
        $finish;
    end

endmodule
